/* rtl/assert_macros.svh */
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

/* rtl/ggcpa_pkg.sv */
// Constants and codes of the greedy garbage collection page allocator.
package ggcpa_pkg;
   localparam int PAGES_PER_BLOCK = 64;
   localparam int BLOCK_COUNT = 256;
   localparam int TOTAL_PAGES = PAGES_PER_BLOCK * BLOCK_COUNT;
   localparam int PAGE_BITS = $clog2(PAGES_PER_BLOCK);
   localparam int BLOCK_BITS = $clog2(BLOCK_COUNT);
   localparam int PADDR_W = 14;
   localparam int LBA_W = 32;
   localparam int CNT_W = $clog2(2 * PAGES_PER_BLOCK);
   localparam int IC_LIMIT = 2 * PAGES_PER_BLOCK - 1;
   localparam int TOTAL_BITS = $clog2(TOTAL_PAGES);

   typedef enum logic [1:0] {
      CMD_ALLOCATE   = 2'd0,
      CMD_VALIDATE   = 2'd1,
      CMD_INVALIDATE = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_REMAP = 2'd1,
      KIND_ACK   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_ALREADY_VALID = 3'd1,
      ST_ALREADY_INV   = 3'd2,
      ST_NO_FREE       = 3'd3,
      ST_ACTIVE_FULL   = 3'd4,
      ST_VICTIM_VALID  = 3'd5
   } status_type;
endpackage

/* rtl/greedy_gc_page_allocator.sv */
// Flash page allocator with greedy garbage collection, top level.
//
// Commands enter on req_command, req_page_address and req_logical_address and
// are taken when start is high and busy is low. Every result appears for one
// cycle with rsp_valid high; rsp_last marks the final result of a command.
// The receiver cannot stall, so results are never held.
// Validate and invalidate of a page in range read the page memory, then
// write back with the acknowledge. An allocate from a block with room,
// when the free list is not empty, is answered at once; one that opens a
// new block first reads the free list. When the free list runs dry, garbage
// collection scans the invalid counts, one block per cycle, then reads every
// page of the victim and copies each valid one to the active block, stopping
// if it fills, and frees the victim if its invalid count is PAGES_PER_BLOCK.
// After reset the block clears the page memory, the counts and the free list,
// one entry per cycle, over all TOTAL_PAGES (16384) pages, with busy high.
module greedy_gc_page_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [13:0] req_page_address,
   input  logic [31:0] req_logical_address,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [13:0] rsp_new_page,
   output logic [13:0] rsp_old_page,
   output logic [31:0] rsp_moved_logical,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_copies_total,
   output logic        rsp_last
);
`include "assert_macros.svh"

   localparam int PB = ggcpa_pkg::PAGE_BITS;
   localparam int BB = ggcpa_pkg::BLOCK_BITS;
   localparam int CW = ggcpa_pkg::CNT_W;
   localparam int TB = ggcpa_pkg::TOTAL_BITS;
   localparam int LW = ggcpa_pkg::LBA_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RMW, S_FIFO, S_SCAN, S_GC_RD, S_GC_MV, S_GC_WR,
      S_GC_END, S_GC_CHK
   } state_type;

   logic [LW:0] pmem [ggcpa_pkg::TOTAL_PAGES];
   logic [CW-1:0] cmem [ggcpa_pkg::BLOCK_COUNT];
   logic [BB-1:0] fmem [ggcpa_pkg::BLOCK_COUNT];

   state_type state_ff, state_in;
   logic [TB-1:0] clr_ff, clr_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [TB-1:0] page_ff, page_in;
   logic [LW-1:0] lba_ff, lba_in;
   logic [BB-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [BB:0] free_count_ff, free_count_in;
   logic [BB-1:0] active_block_ff, active_block_in;
   logic [PB:0] active_page_ff, active_page_in;
   logic [31:0] copy_count_ff, copy_count_in;
   logic [BB:0] scan_ff, scan_in;
   logic [CW-1:0] best_ff, best_in;
   logic [BB-1:0] victim_ff, victim_in;
   logic [PB-1:0] pg_ff, pg_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [13:0] rsp_new_ff, rsp_new_in, rsp_old_ff, rsp_old_in;
   logic [31:0] rsp_lba_ff, rsp_lba_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic rsp_last_ff, rsp_last_in;

   logic [TB-1:0] pr_addr, pw_addr;
   logic [LW:0] pr_data_ff, pw_data;
   logic pw_en;
   logic [BB-1:0] cr_addr, cw_addr, fr_addr, fw_addr;
   logic [CW-1:0] cr_data_ff, cw_data;
   logic cw_en, fw_en;
   logic [BB-1:0] fr_data_ff, fw_data;

   always_ff @(posedge clock) begin
      if (pw_en) begin
         pmem[pw_addr] <= pw_data;
      end
      pr_data_ff <= pmem[pr_addr];
      if (cw_en) begin
         cmem[cw_addr] <= cw_data;
      end
      cr_data_ff <= cmem[cr_addr];
      if (fw_en) begin
         fmem[fw_addr] <= fw_data;
      end
      fr_data_ff <= fmem[fr_addr];
   end

   always_comb begin
      logic [TB-1:0] dst;
      logic [CW-1:0] inc;
      logic [BB:0] free_dec;
      state_in = state_ff;
      clr_in = clr_ff;
      cmd_in = cmd_ff;
      page_in = page_ff;
      lba_in = lba_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      free_count_in = free_count_ff;
      active_block_in = active_block_ff;
      active_page_in = active_page_ff;
      copy_count_in = copy_count_ff;
      scan_in = scan_ff;
      best_in = best_ff;
      victim_in = victim_ff;
      pg_in = pg_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in = ggcpa_pkg::KIND_ALLOC;
      rsp_new_in = '0;
      rsp_old_in = '0;
      rsp_lba_in = '0;
      rsp_status_in = ggcpa_pkg::ST_OK;
      rsp_last_in = 1'b1;
      pr_addr = req_page_address[TB-1:0];
      pw_addr = clr_ff;
      pw_data = {1'b0, {LW{1'b1}}};
      pw_en = 1'b0;
      cr_addr = req_page_address[TB-1 -: BB];
      cw_addr = clr_ff[BB-1:0];
      cw_data = '0;
      cw_en = 1'b0;
      fr_addr = head_ff;
      fw_addr = clr_ff[BB-1:0];
      fw_data = clr_ff[BB-1:0];
      fw_en = 1'b0;
      dst = {active_block_ff, active_page_ff[PB-1:0]};
      inc = (cr_data_ff < CW'(ggcpa_pkg::IC_LIMIT)) ? cr_data_ff + CW'(1) : cr_data_ff;
      free_dec = free_count_ff - (BB+1)'(1);
      case (state_ff)
         S_CLEAR: begin
            pw_en = 1'b1;
            cw_en = 1'b1;
            fw_en = 1'b1;
            clr_in = clr_ff + TB'(1);
            if (clr_ff == TB'(ggcpa_pkg::TOTAL_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in = req_command;
               page_in = req_page_address[TB-1:0];
               lba_in = req_logical_address;
               if (req_command == ggcpa_pkg::CMD_ALLOCATE) begin
                  if (active_page_ff >= (PB+1)'(ggcpa_pkg::PAGES_PER_BLOCK)) begin
                     if (free_count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = ggcpa_pkg::ST_NO_FREE;
                     end else begin
                        state_in = S_FIFO;
                     end
                  end else if (free_count_ff == '0) begin
                     scan_in = '0;
                     state_in = S_SCAN;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_new_in = 14'(dst);
                     active_page_in = active_page_ff + (PB+1)'(1);
                  end
               end else if ((req_command == ggcpa_pkg::CMD_VALIDATE ||
                             req_command == ggcpa_pkg::CMD_INVALIDATE) &&
                            32'(req_page_address) < ggcpa_pkg::TOTAL_PAGES) begin
                  state_in = S_RMW;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in = ggcpa_pkg::KIND_ACK;
               end
            end
         end
         S_RMW: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in = ggcpa_pkg::KIND_ACK;
            pw_addr = page_ff;
            cw_addr = page_ff[TB-1 -: BB];
            if (cmd_ff == ggcpa_pkg::CMD_VALIDATE) begin
               if (pr_data_ff[LW]) begin
                  rsp_status_in = ggcpa_pkg::ST_ALREADY_VALID;
               end else begin
                  pw_en = 1'b1;
                  pw_data = {1'b1, lba_ff};
               end
            end else begin
               if (!pr_data_ff[LW]) begin
                  rsp_status_in = ggcpa_pkg::ST_ALREADY_INV;
               end else begin
                  pw_en = 1'b1;
                  cw_en = 1'b1;
                  cw_data = inc;
               end
            end
            state_in = S_IDLE;
         end
         S_FIFO: begin
            active_block_in = fr_data_ff;
            head_in = head_ff + BB'(1);
            free_count_in = free_dec;
            if (free_dec == '0) begin
               active_page_in = '0;
               scan_in = '0;
               state_in = S_SCAN;
            end else begin
               active_page_in = (PB+1)'(1);
               rsp_valid_in = 1'b1;
               rsp_new_in = 14'({fr_data_ff, {PB{1'b0}}});
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cr_addr = scan_ff[BB-1:0];
            if (scan_ff == (BB+1)'(1)) begin
               best_in = cr_data_ff;
               victim_in = '0;
            end else if (scan_ff != '0 && cr_data_ff > best_ff) begin
               best_in = cr_data_ff;
               victim_in = BB'(scan_ff - (BB+1)'(1));
            end
            if (scan_ff == (BB+1)'(ggcpa_pkg::BLOCK_COUNT)) begin
               pg_in = '0;
               state_in = S_GC_RD;
            end else begin
               scan_in = scan_ff + (BB+1)'(1);
            end
         end
         S_GC_RD: begin
            pr_addr = {victim_ff, pg_ff};
            cr_addr = victim_ff;
            state_in = S_GC_MV;
         end
         S_GC_MV: begin
            if (!pr_data_ff[LW]) begin
               pg_in = pg_ff + PB'(1);
               state_in = (pg_ff == PB'(ggcpa_pkg::PAGES_PER_BLOCK - 1)) ? S_GC_END
                                                                         : S_GC_RD;
            end else if (active_page_ff + (PB+1)'(1) >=
                         (PB+1)'(ggcpa_pkg::PAGES_PER_BLOCK)) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = ggcpa_pkg::ST_ACTIVE_FULL;
               state_in = S_IDLE;
            end else begin
               copy_count_in = copy_count_ff + 32'd1;
               pw_en = 1'b1;
               pw_addr = {victim_ff, pg_ff};
               cw_en = 1'b1;
               cw_addr = victim_ff;
               cw_data = inc;
               lba_in = pr_data_ff[LW-1:0];
               state_in = S_GC_WR;
            end
         end
         S_GC_WR: begin
            pw_en = 1'b1;
            pw_addr = dst;
            pw_data = {1'b1, lba_ff};
            rsp_valid_in = 1'b1;
            rsp_kind_in = ggcpa_pkg::KIND_REMAP;
            rsp_new_in = 14'(dst);
            rsp_old_in = 14'({victim_ff, pg_ff});
            rsp_lba_in = lba_ff;
            rsp_last_in = 1'b0;
            active_page_in = active_page_ff + (PB+1)'(1);
            pg_in = pg_ff + PB'(1);
            state_in = (pg_ff == PB'(ggcpa_pkg::PAGES_PER_BLOCK - 1)) ? S_GC_END : S_GC_RD;
         end
         S_GC_END: begin
            cr_addr = victim_ff;
            state_in = S_GC_CHK;
         end
         S_GC_CHK: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
            if (cr_data_ff != CW'(ggcpa_pkg::PAGES_PER_BLOCK)) begin
               rsp_status_in = ggcpa_pkg::ST_VICTIM_VALID;
            end else begin
               cw_en = 1'b1;
               cw_addr = victim_ff;
               cw_data = '0;
               if (free_count_ff < (BB+1)'(ggcpa_pkg::BLOCK_COUNT)) begin
                  fw_en = 1'b1;
                  fw_addr = tail_ff;
                  fw_data = victim_ff;
                  tail_in = tail_ff + BB'(1);
                  free_count_in = free_count_ff + (BB+1)'(1);
               end
               rsp_new_in = 14'(dst);
               active_page_in = active_page_ff + (PB+1)'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         free_count_ff <= (BB+1)'(ggcpa_pkg::BLOCK_COUNT);
         active_block_ff <= '0;
         active_page_ff <= (PB+1)'(ggcpa_pkg::PAGES_PER_BLOCK);
         copy_count_ff <= '0;
         scan_ff <= '0;
         pg_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         free_count_ff <= free_count_in;
         active_block_ff <= active_block_in;
         active_page_ff <= active_page_in;
         copy_count_ff <= copy_count_in;
         scan_ff <= scan_in;
         pg_ff <= pg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      page_ff <= page_in;
      lba_ff <= lba_in;
      best_ff <= best_in;
      victim_ff <= victim_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_new_ff <= rsp_new_in;
      rsp_old_ff <= rsp_old_in;
      rsp_lba_ff <= rsp_lba_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_new_page = rsp_new_ff;
   assign rsp_old_page = rsp_old_ff;
   assign rsp_moved_logical = rsp_lba_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_copies_total = copy_count_ff;
   assign rsp_last = rsp_last_ff;

   `ASSERT_NEXT(a_cmd_progress, clock, reset, start && !busy, busy || rsp_valid)
   `ASSERT_IMPLIES(a_free_bound, clock, reset, 1'b1,
                   free_count_ff <= (BB+1)'(ggcpa_pkg::BLOCK_COUNT))
   `ASSERT_IMPLIES(a_page_bound, clock, reset, 1'b1,
                   active_page_ff <= (PB+1)'(ggcpa_pkg::PAGES_PER_BLOCK))
   `ASSERT_IMPLIES(a_remap_not_last, clock, reset,
                   rsp_valid && rsp_kind == ggcpa_pkg::KIND_REMAP, !rsp_last)
endmodule
